// ----- sv/chunked_message_deframer_macros.svh -----
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry assertions.
`ifndef CHUNKED_MESSAGE_DEFRAMER_MACROS_SVH
`define CHUNKED_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define CMD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/cmd_pkg.sv -----
// Types and constants for the chunked message deframer.
// No dependencies; used by cmd_parser and chunked_message_deframer.
package cmd_pkg;

   localparam int HS_BYTES = 20;
   localparam int HS_CNT_W = $clog2(HS_BYTES + 1);
   localparam int LEN_W = 25;
   localparam int CHUNK_W = 16;
   localparam logic [LEN_W-1:0] HARD_LIMIT = 25'd16777216;

   localparam logic [7:0] MAGIC [4] = '{8'h60, 8'h60, 8'hb0, 8'h17};

   typedef enum logic [2:0] {
      PH_HANDSHAKE,
      PH_HDR_HIGH,
      PH_HDR_LOW,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      K_PAYLOAD   = 3'd0,
      K_END       = 3'd1,
      K_HS_OK     = 3'd2,
      K_HS_BAD    = 3'd3,
      K_TOO_LARGE = 3'd4
   } kind_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [7:0]       data;
      logic [LEN_W-1:0] length;
   } result_type;

endpackage

// ----- sv/cmd_parser.sv -----
// Deframer state machine: handshake check, chunk headers, payload count.
// Depends on cmd_pkg and chunked_message_deframer_macros.svh.
`include "chunked_message_deframer_macros.svh"

module cmd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   input  logic [cmd_pkg::LEN_W-1:0] max_bytes,
   output cmd_pkg::result_type       result
);

   cmd_pkg::phase_type          phase_ff, phase_in;
   logic [cmd_pkg::HS_CNT_W-1:0] hs_count_ff, hs_count_in;
   logic                         magic_ok_ff, magic_ok_in;
   logic [7:0]                   hdr_high_ff, hdr_high_in;
   logic [cmd_pkg::CHUNK_W-1:0]  remain_ff, remain_in;
   logic [cmd_pkg::LEN_W-1:0]    total_ff, total_in;

   logic [cmd_pkg::CHUNK_W-1:0]  size;
   logic [cmd_pkg::LEN_W-1:0]    limit;
   logic [cmd_pkg::LEN_W:0]      sum;
   logic                         magic_hit;

   assign size  = {hdr_high_ff, rx_byte};
   assign limit = (max_bytes > cmd_pkg::HARD_LIMIT) ? cmd_pkg::HARD_LIMIT : max_bytes;
   assign sum   = {1'b0, total_ff} + (cmd_pkg::LEN_W + 1)'(size);
   assign magic_hit = (hs_count_ff >= cmd_pkg::HS_CNT_W'(4)) ||
                      (rx_byte == cmd_pkg::MAGIC[hs_count_ff[1:0]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cmd_pkg::PH_HANDSHAKE;
         hs_count_ff <= '0;
         magic_ok_ff <= 1'b1;
         hdr_high_ff <= '0;
         remain_ff   <= '0;
         total_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         hs_count_ff <= hs_count_in;
         magic_ok_ff <= magic_ok_in;
         hdr_high_ff <= hdr_high_in;
         remain_ff   <= remain_in;
         total_ff    <= total_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hs_count_in   = hs_count_ff;
      magic_ok_in   = magic_ok_ff;
      hdr_high_in   = hdr_high_ff;
      remain_in     = remain_ff;
      total_in      = total_ff;
      result.valid  = 1'b0;
      result.kind   = cmd_pkg::K_PAYLOAD;
      result.data   = '0;
      result.length = '0;
      if (step) begin
         case (phase_ff)
            cmd_pkg::PH_HANDSHAKE: begin
               magic_ok_in = magic_ok_ff & magic_hit;
               hs_count_in = hs_count_ff + 1'b1;
               if (hs_count_ff == cmd_pkg::HS_CNT_W'(cmd_pkg::HS_BYTES - 1)) begin
                  result.valid = 1'b1;
                  if (magic_ok_in) begin
                     phase_in    = cmd_pkg::PH_HDR_HIGH;
                     result.kind = cmd_pkg::K_HS_OK;
                  end else begin
                     phase_in    = cmd_pkg::PH_HALT;
                     result.kind = cmd_pkg::K_HS_BAD;
                  end
               end
            end
            cmd_pkg::PH_HDR_HIGH: begin
               hdr_high_in = rx_byte;
               phase_in    = cmd_pkg::PH_HDR_LOW;
            end
            cmd_pkg::PH_HDR_LOW: begin
               if (size == '0) begin
                  phase_in = cmd_pkg::PH_HDR_HIGH;
                  if (total_ff != '0) begin
                     result.valid  = 1'b1;
                     result.kind   = cmd_pkg::K_END;
                     result.length = total_ff;
                     total_in      = '0;
                  end
               end else if (sum > {1'b0, limit}) begin
                  phase_in     = cmd_pkg::PH_HALT;
                  result.valid = 1'b1;
                  result.kind  = cmd_pkg::K_TOO_LARGE;
               end else begin
                  remain_in = size;
                  phase_in  = cmd_pkg::PH_PAYLOAD;
               end
            end
            cmd_pkg::PH_PAYLOAD: begin
               total_in     = total_ff + 1'b1;
               remain_in    = remain_ff - 1'b1;
               if (remain_in == '0) begin
                  phase_in = cmd_pkg::PH_HDR_HIGH;
               end
               result.valid = 1'b1;
               result.kind  = cmd_pkg::K_PAYLOAD;
               result.data  = rx_byte;
            end
            default: begin
            end
         endcase
      end
   end

   `CMD_ASSERT_NOW(a_payload_nonempty, phase_ff == cmd_pkg::PH_PAYLOAD, remain_ff != '0)
   `CMD_ASSERT_NEXT(a_halt_sticky, phase_ff == cmd_pkg::PH_HALT, phase_ff == cmd_pkg::PH_HALT)
   `CMD_ASSERT_NOW(a_hs_count_range, 1'b1, hs_count_ff <= cmd_pkg::HS_CNT_W'(cmd_pkg::HS_BYTES))
   `CMD_ASSERT_NOW(a_total_bounded, 1'b1, total_ff <= cmd_pkg::HARD_LIMIT)
   `CMD_ASSERT_NOW(a_payload_phase, result.valid && result.kind == cmd_pkg::K_PAYLOAD,
      phase_ff == cmd_pkg::PH_PAYLOAD)

endmodule

// ----- sv/chunked_message_deframer.sv -----
// Top level of the chunked message deframer: input register, parser, result register.
// Depends on cmd_pkg and cmd_parser.
//
//   channel  direction  payload                              accepted when
//   req_     in         tdata = rx_byte                      tvalid & tready
//   rsp_     out        tdata = data, message_length; tuser = kind   tvalid & tready
//   csr_     in         data = max_message_bytes             valid & ready (always ready)
//
// One word per cycle sustained while rsp_ is not stalled; a word is held in the input register
// and is parsed into the result register once that register is empty or being drained.
// Reset (synchronous) returns to the handshake phase and sets the limit to 2^24.
// A stalled result holds the result register; the input register then fills and
// req_tready drops. Words that produce no result leave no trace on rsp_.
module chunked_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data, [32:8] message_length, [39:33] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [24:0] csr_data
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic [cmd_pkg::LEN_W-1:0] max_ff;
   logic                      out_valid_ff, out_valid_in;
   cmd_pkg::result_type       out_ff;
   cmd_pkg::result_type       result;
   logic                      advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign csr_ready   = 1'b1;
   assign in_valid_in = req_tvalid || (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && !rsp_tready);

   cmd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .max_bytes (max_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= cmd_pkg::HARD_LIMIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {7'd0, out_ff.length, out_ff.data};

endmodule
